// ===== rtl/smooth_central_difference_derivative_macros.svh =====
// assertion macros for the smooth central difference derivative block
`ifndef SMOOTH_CENTRAL_DIFFERENCE_DERIVATIVE_MACROS_SVH
`define SMOOTH_CENTRAL_DIFFERENCE_DERIVATIVE_MACROS_SVH
`ifndef SYNTHESIS
`define SCDD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scdd assertion failed");
`define SCDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scdd assertion failed");
`else
`define SCDD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/scdd_pkg.sv =====
// shared constants and coefficient table for the smooth derivative block
`default_nettype none
package scdd_pkg;
    localparam int MAX_HALF_TAPS_DEF = 7;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRAC_BITS         = 8;
    localparam int TAPS_W            = 3;
    localparam int STEP_W            = 16;
    localparam int COEF_W            = 10;
    localparam int SH_W              = 5;
    localparam int OUT_W             = 32;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TAPS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RECIP = 1'd1;

    localparam logic [TAPS_W-1:0] HALF_TAPS_RST  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_RECIP_RST = 16'd256;

    // d_k = C(2m, m-k+1) - C(2m, m-k-1) with m = taps-1
    function automatic logic [COEF_W-1:0] tap_coef(input logic [TAPS_W-1:0] taps,
                                                   input logic [TAPS_W-1:0] k);
        logic [COEF_W-1:0] c;
        case ({taps, k})
            {3'd1, 3'd1}: c = 10'd1;
            {3'd2, 3'd1}: c = 10'd2;
            {3'd2, 3'd2}: c = 10'd1;
            {3'd3, 3'd1}: c = 10'd5;
            {3'd3, 3'd2}: c = 10'd4;
            {3'd3, 3'd3}: c = 10'd1;
            {3'd4, 3'd1}: c = 10'd14;
            {3'd4, 3'd2}: c = 10'd14;
            {3'd4, 3'd3}: c = 10'd6;
            {3'd4, 3'd4}: c = 10'd1;
            {3'd5, 3'd1}: c = 10'd42;
            {3'd5, 3'd2}: c = 10'd48;
            {3'd5, 3'd3}: c = 10'd27;
            {3'd5, 3'd4}: c = 10'd8;
            {3'd5, 3'd5}: c = 10'd1;
            {3'd6, 3'd1}: c = 10'd132;
            {3'd6, 3'd2}: c = 10'd165;
            {3'd6, 3'd3}: c = 10'd110;
            {3'd6, 3'd4}: c = 10'd44;
            {3'd6, 3'd5}: c = 10'd10;
            {3'd6, 3'd6}: c = 10'd1;
            {3'd7, 3'd1}: c = 10'd429;
            {3'd7, 3'd2}: c = 10'd572;
            {3'd7, 3'd3}: c = 10'd429;
            {3'd7, 3'd4}: c = 10'd208;
            {3'd7, 3'd5}: c = 10'd65;
            {3'd7, 3'd6}: c = 10'd12;
            {3'd7, 3'd7}: c = 10'd1;
            default:      c = '0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/smooth_central_difference_derivative.sv =====
// Smoothed first-derivative estimator over a streamed record of signed samples.
// A sample is taken only while the sequencer is idle. Each derivative then
// runs through one shared multiplier, with per tap pair a two-port window
// read, a difference, a multiply by the tap coefficient and an accumulate,
// then a scale by step_recip on the same multiplier and a shift and saturate
// into the output register. A sample that yields no result only enters the
// window, and the last sample of a record also flushes the results for the
// record's remaining samples. A full output register that is not drained
// holds the sequencer in its final step. The window is a circular buffer of
// 2*MAX_HALF_TAPS+1 entries; no clearing pass is needed since only samples of
// the current record are ever read.
`default_nettype none
module smooth_central_difference_derivative
    import scdd_pkg::*;
#(
    parameter int MAX_HALF_TAPS = MAX_HALF_TAPS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, rest zero
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire                             s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [31:0] derivative
    output logic [OUT_W-1:0]                m_axis_tdata,
    output logic                            m_axis_tlast,
    input  wire                             i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]            i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]           i_cfg_data
);
    `include "smooth_central_difference_derivative_macros.svh"

    localparam int WIN    = 2 * MAX_HALF_TAPS + 1;
    localparam int AGE_W  = $clog2(WIN);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int ACC_W  = SAMPLE_BITS + 13;
    localparam int MULB_W = STEP_W + 1;
    localparam int PROD_W = ACC_W + MULB_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_DIFF  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_SHIFT = 3'd6;

    localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-31){1'b1}}, 31'b0};

    logic [2:0]              r_state, n_state;
    logic [TAPS_W-1:0]       r_half;
    logic [STEP_W-1:0]       r_step;
    logic [AGE_W-1:0]        r_np;
    logic [CNT_W-1:0]        r_seen;
    logic [CNT_W-1:0]        r_count;
    logic [AGE_W-1:0]        r_taps;
    logic [AGE_W-1:0]        r_k;
    logic [AGE_W-1:0]        r_age;
    logic [SH_W-1:0]         r_sh;
    logic                    r_last;
    logic signed [SAMPLE_BITS-1:0] r_mem [WIN];
    logic signed [SAMPLE_BITS-1:0] r_rd_a, r_rd_b;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic                    r_out_last;

    logic                    in_acc;
    logic                    out_free;
    logic                    load_out;
    logic [TAPS_W-1:0]       taps_c;
    logic [CNT_W-1:0]        count_new;
    logic [CNT_W-1:0]        count_m1;
    logic [AGE_W-1:0]        np_next;
    logic [AGE_W-1:0]        age_lo, age_hi, age_max;
    logic [AGE_W-1:0]        addr_lo, addr_hi;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] shifted;
    logic [OUT_W-1:0]        sat_val;
    logic                    emit_done;

    function automatic logic [AGE_W-1:0] age_addr(input logic [AGE_W-1:0] np,
                                                  input logic [AGE_W-1:0] age);
        logic [AGE_W:0] wrap;
        wrap = {1'b0, np} + (AGE_W+1)'(WIN) - {1'b0, age};
        return (np >= age) ? (np - age) : wrap[AGE_W-1:0];
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign load_out      = (r_state == S_SHIFT) && out_free;
    assign emit_done     = !r_last || (r_age == '0);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        if (r_half == '0) begin
            taps_c = TAPS_W'(1);
        end else if (r_half > TAPS_W'(MAX_HALF_TAPS)) begin
            taps_c = TAPS_W'(MAX_HALF_TAPS);
        end else begin
            taps_c = r_half;
        end
        count_new = (r_seen == CNT_W'(WIN)) ? CNT_W'(WIN) : r_seen + CNT_W'(1);
        count_m1  = count_new - CNT_W'(1);
        np_next   = (r_np == AGE_W'(WIN - 1)) ? '0 : r_np + AGE_W'(1);
    end

    // tap ages clamped to the record's extent
    always_comb begin
        age_max = AGE_W'(r_count - CNT_W'(1));
        age_lo  = (r_k > r_age) ? '0 : r_age - r_k;
        age_hi  = r_age + r_k;
        if (age_hi > age_max) begin
            age_hi = age_max;
        end
        addr_lo = age_addr(r_np, age_lo);
        addr_hi = age_addr(r_np, age_hi);
    end

    // shared multiplier: tap coefficient or step scaling
    always_comb begin
        if (r_state == S_SCALE) begin
            mul_a = r_acc;
            mul_b = $signed({1'b0, r_step});
        end else begin
            mul_a = ACC_W'(r_diff);
            mul_b = $signed({1'b0, STEP_W'(tap_coef(TAPS_W'(r_taps), TAPS_W'(r_k)))});
        end
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        shifted = r_prod >>> r_sh;
        if (shifted > SAT_HI) begin
            sat_val = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (shifted < SAT_LO) begin
            sat_val = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_val = shifted[OUT_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tlast || count_new >= CNT_W'(taps_c) + CNT_W'(1))) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_k == r_taps) ? S_SCALE : S_RD;
            S_SCALE: n_state = S_SHIFT;
            S_SHIFT: begin
                if (out_free) begin
                    n_state = emit_done ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_half  <= HALF_TAPS_RST;
            r_step  <= STEP_RECIP_RST;
            r_np    <= AGE_W'(WIN - 1);
            r_seen  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HALF_TAPS:  r_half <= i_cfg_data[TAPS_W-1:0];
                    CFG_STEP_RECIP: r_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_np   <= np_next;
                r_seen <= s_axis_tlast ? '0 : count_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_count <= count_new;
            r_taps  <= AGE_W'(taps_c);
            r_last  <= s_axis_tlast;
            r_sh    <= SH_W'({taps_c, 1'b0}) + SH_W'(FRAC_BITS - 1);
            r_k     <= AGE_W'(1);
            r_acc   <= '0;
            if (s_axis_tlast && (count_m1 < CNT_W'(taps_c))) begin
                r_age <= AGE_W'(count_m1);
            end else begin
                r_age <= AGE_W'(taps_c);
            end
        end
        case (r_state)
            S_DIFF:  r_diff <= {r_rd_a[SAMPLE_BITS-1], r_rd_a} - {r_rd_b[SAMPLE_BITS-1], r_rd_b};
            S_MUL:   r_prod <= mul_p;
            S_ACC: begin
                r_acc <= r_acc + $signed(r_prod[ACC_W-1:0]);
                if (r_k != r_taps) begin
                    r_k <= r_k + AGE_W'(1);
                end
            end
            S_SCALE: r_prod <= mul_p;
            S_SHIFT: begin
                if (out_free && !emit_done) begin
                    r_age <= r_age - AGE_W'(1);
                    r_k   <= AGE_W'(1);
                    r_acc <= '0;
                end
            end
            default: ;
        endcase
    end

    // window memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[np_next] <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
        end
        if (r_state == S_RD) begin
            r_rd_a <= r_mem[addr_lo];
            r_rd_b <= r_mem[addr_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= sat_val;
            r_out_last <= r_last && (r_age == '0);
        end
    end

    `SCDD_ASSERT_NEXT(a_last_flushes, i_clk, i_rst_n, in_acc && s_axis_tlast,
        (r_state == S_RD) && (r_seen == '0))
    `SCDD_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, load_out,
        r_out_valid && (r_out_data == $past(sat_val)))
    `SCDD_ASSERT_SAME(a_tap_in_range, i_clk, i_rst_n, r_state != S_IDLE,
        (r_k != '0) && (r_k <= r_taps) && (r_age <= r_taps))

endmodule
`default_nettype wire
